FILE: hdl/lpt_pkg.sv
`default_nettype none
package lpt_pkg;
  localparam int NumPointsDef = 15;
  localparam int NumScenariosDef = 4;
  localparam int TimeBitsDef = 48;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 24;
  localparam logic [23:0] TimeoutReclaimRst = 24'd2000000;
  localparam logic [23:0] TimeoutFaultRst = 24'd100000;
  localparam logic [23:0] TimeoutBatchRst = 24'd500000;
  localparam logic [23:0] TimeoutPrefetchRst = 24'd2000000;
  localparam logic [47:0] BucketHiUs = 48'd500000;
  localparam logic [47:0] BucketLoUs = 48'd100000;
  localparam logic [3:0] AsyncLoadA = 4'd10;
  localparam logic [3:0] AsyncLoadB = 4'd11;
  localparam logic [1:0] FaultScen = 2'd1;

  typedef enum logic [2:0] {
    CMD_BEGIN = 3'd0, CMD_START = 3'd1, CMD_END = 3'd2,
    CMD_MARK = 3'd3, CMD_ASYNC = 3'd4, CMD_FINISH = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    REG_RECLAIM = 2'd0, REG_FAULT = 2'd1, REG_BATCH = 2'd2, REG_PREFETCH = 2'd3
  } reg_e;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_OUT} state_e;

  typedef struct packed {
    logic load;  // capture input item
    logic exec;  // perform update, write result register
  } ctl_t;
endpackage
`default_nettype wire

FILE: hdl/lpt_if.sv
`default_nettype none
interface lpt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [3:0]  point;
  logic [1:0]  scenario;
  logic [47:0] time_us;
  logic [47:0] start_time_us;
  logic [63:0] ravg_now;
  logic [63:0] ravg_start;
  logic        foreground;
  modport source(output valid, cmd, point, scenario, time_us, start_time_us,
                 ravg_now, ravg_start, foreground, input ready);
  modport sink(input valid, cmd, point, scenario, time_us, start_time_us,
               ravg_now, ravg_start, foreground, output ready);
endinterface

interface lpt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_starts;
  logic [31:0] point_ends;
  logic [63:0] point_total_us;
  logic [47:0] point_max_us;
  logic [63:0] point_load_total;
  logic [47:0] request_latency_us;
  logic        request_timed_out;
  logic [1:0]  fault_bucket;
  logic [63:0] scenario_total_us;
  logic [47:0] scenario_max_us;
  logic [31:0] scenario_timeouts;
  logic [31:0] bucket_count;
  modport source(output valid, point_starts, point_ends, point_total_us, point_max_us,
                 point_load_total, request_latency_us, request_timed_out, fault_bucket,
                 scenario_total_us, scenario_max_us, scenario_timeouts, bucket_count,
                 input ready);
  modport sink(input valid, point_starts, point_ends, point_total_us, point_max_us,
               point_load_total, request_latency_us, request_timed_out, fault_bucket,
               scenario_total_us, scenario_max_us, scenario_timeouts, bucket_count,
               output ready);
endinterface

interface lpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/lpt_ctrl.sv
`default_nettype none
module lpt_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         in_drop_i,
  input  wire logic         out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output lpt_pkg::ctl_t     ctl_o
);
  import lpt_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    ctl_o = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (in_drop_i) state_d = ST_IDLE;
        else begin
          ctl_o.exec = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        in_ready_o = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            ctl_o.load = 1'b1;
            state_d = ST_EXEC;
          end else state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/lpt_datapath.sv
`default_nettype none
module lpt_datapath #(
  parameter int NumScenarios = lpt_pkg::NumScenariosDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire lpt_pkg::ctl_t ctl_i,
  output logic             drop_o,
  lpt_in_if.sink           in_if,
  lpt_cfg_if.sink          cfg_if,
  lpt_out_if.source        out_if
);
  import lpt_pkg::*;
  localparam int NumPoints = NumPointsDef;
  localparam int TimeBits = TimeBitsDef;
  localparam int PW = $clog2(NumPoints);
  localparam logic [3:0] DonePt = 4'(NumPoints - 1);

  logic [2:0] cmd_q;
  logic [3:0] pt_q;
  logic [1:0] scen_in_q;
  logic [TimeBits-1:0] t_q, ts_q;
  logic [63:0] rnow_q, rstart_q;
  logic fg_q;

  logic [31:0] sc_q [NumPoints];
  logic [31:0] ec_q [NumPoints];
  logic [TimeBits-1:0] ft_q [NumPoints];
  logic [TimeBits-1:0] lt_q [NumPoints];
  logic [63:0] it_q [NumPoints];
  logic [TimeBits-1:0] im_q [NumPoints];
  logic [63:0] ll_q [NumPoints];
  logic [63:0] lo_q [NumPoints];
  logic [1:0] cur_scen_q;
  logic [63:0] stot_q [NumScenarios];
  logic [TimeBits-1:0] smax_q [NumScenarios];
  logic [31:0] sto_q [NumScenarios];
  logic [31:0] fb_q [4];
  logic [23:0] tmo_q [4];

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q[REG_RECLAIM] <= TimeoutReclaimRst;
      tmo_q[REG_FAULT] <= TimeoutFaultRst;
      tmo_q[REG_BATCH] <= TimeoutBatchRst;
      tmo_q[REG_PREFETCH] <= TimeoutPrefetchRst;
    end else if (cfg_if.valid) begin
      tmo_q[cfg_if.index] <= cfg_if.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= in_if.cmd; pt_q <= in_if.point; scen_in_q <= in_if.scenario;
      t_q <= in_if.time_us[TimeBits-1:0]; ts_q <= in_if.start_time_us[TimeBits-1:0];
      rnow_q <= in_if.ravg_now; rstart_q <= in_if.ravg_start; fg_q <= in_if.foreground;
    end
  end

  logic is_pt_cmd, bad_pt;
  assign is_pt_cmd = cmd_q == CMD_START || cmd_q == CMD_END || cmd_q == CMD_MARK ||
                     cmd_q == CMD_ASYNC;
  assign bad_pt = {28'd0, pt_q} >= 32'(NumPoints);
  assign drop_o = (cmd_q > CMD_FINISH) || (is_pt_cmd && bad_pt);

  // Resolve the addressed entry, its old contents (zero for begin) and its update.
  logic [3:0] p;
  logic [PW-1:0] pi;
  logic clr;
  logic [31:0] sc0, ec0, sc1, ec1;
  logic [TimeBits-1:0] ft0, lt0, im0, ft1, lt1, im1, d, et, ent;
  logic [63:0] it0, ll0, lo0, it1, ll1, lo1, eld, enl;
  logic do_enter, do_leave, bump_end;

  always_comb begin
    clr = cmd_q == CMD_BEGIN;
    p = clr ? 4'd0 : (cmd_q == CMD_FINISH) ? DonePt : pt_q;
    pi = p[PW-1:0];
    sc0 = clr ? '0 : sc_q[pi]; ec0 = clr ? '0 : ec_q[pi];
    ft0 = clr ? '0 : ft_q[pi]; lt0 = clr ? '0 : lt_q[pi];
    it0 = clr ? '0 : it_q[pi]; im0 = clr ? '0 : im_q[pi];
    ll0 = clr ? '0 : ll_q[pi]; lo0 = clr ? '0 : lo_q[pi];
    do_enter = cmd_q != CMD_END;
    do_leave = cmd_q == CMD_END || cmd_q == CMD_ASYNC;
    bump_end = clr || cmd_q == CMD_MARK || cmd_q == CMD_FINISH;
    ent = (clr || cmd_q == CMD_ASYNC) ? ts_q : t_q;
    enl = (clr || cmd_q == CMD_ASYNC) ? rstart_q : rnow_q;
    eld = rnow_q;
    if (cmd_q == CMD_ASYNC && !(pt_q == AsyncLoadA || pt_q == AsyncLoadB)) eld = '0;
    et = t_q;
    sc1 = sc0; ec1 = ec0; ft1 = ft0; lt1 = lt0; it1 = it0; im1 = im0; ll1 = ll0; lo1 = lo0;
    if (do_enter) begin
      if (sc0 == 0) ft1 = ent;
      sc1 = sc0 + 32'd1; lt1 = ent; ll1 = enl;
    end
    d = et - lt1;
    if (do_leave) begin
      it1 = it0 + 64'(d);
      if (d > im0) im1 = d;
      lo1 = lo0 + (eld - ll1);
      lt1 = et; ll1 = eld;
    end
    if (do_leave || bump_end) ec1 = ec0 + 32'd1;
  end

  // Finish statistics.
  logic [TimeBits-1:0] lat, smax1;
  logic has_stat, tmo_hit, hi, lo_b;
  logic [1:0] fb_idx;
  logic [63:0] stot1;
  logic [31:0] sto1, fb1;
  always_comb begin
    lat = ft1 - ft_q[0];
    has_stat = {30'd0, cur_scen_q} < 32'(NumScenarios);
    stot1 = stot_q[cur_scen_q] + 64'(lat);
    smax1 = (lat > smax_q[cur_scen_q]) ? lat : smax_q[cur_scen_q];
    tmo_hit = lat > TimeBits'(tmo_q[cur_scen_q]);
    sto1 = sto_q[cur_scen_q] + (tmo_hit ? 32'd1 : 32'd0);
    hi = lat > TimeBits'(BucketHiUs);
    lo_b = lat > TimeBits'(BucketLoUs);
    fb_idx = {fg_q, hi};
    fb1 = fb_q[fb_idx] + 32'd1;
  end
  logic fin, bucket_on;
  assign fin = ctl_i.exec && cmd_q == CMD_FINISH && has_stat;
  assign bucket_on = cur_scen_q == FaultScen && tmo_hit && (hi || lo_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_scen_q <= '0;
      for (int i = 0; i < NumPoints; i++) begin
        sc_q[i] <= '0; ec_q[i] <= '0; ft_q[i] <= '0; lt_q[i] <= '0;
        it_q[i] <= '0; im_q[i] <= '0; ll_q[i] <= '0; lo_q[i] <= '0;
      end
      for (int i = 0; i < NumScenarios; i++) begin
        stot_q[i] <= '0; smax_q[i] <= '0; sto_q[i] <= '0;
      end
      for (int i = 0; i < 4; i++) fb_q[i] <= '0;
    end else if (ctl_i.exec) begin
      if (clr) begin
        cur_scen_q <= scen_in_q;
        for (int i = 1; i < NumPoints; i++) begin
          sc_q[i] <= '0; ec_q[i] <= '0; ft_q[i] <= '0; lt_q[i] <= '0;
          it_q[i] <= '0; im_q[i] <= '0; ll_q[i] <= '0; lo_q[i] <= '0;
        end
      end
      sc_q[pi] <= sc1; ec_q[pi] <= ec1; ft_q[pi] <= ft1; lt_q[pi] <= lt1;
      it_q[pi] <= it1; im_q[pi] <= im1; ll_q[pi] <= ll1; lo_q[pi] <= lo1;
      if (fin) begin
        stot_q[cur_scen_q] <= stot1; smax_q[cur_scen_q] <= smax1; sto_q[cur_scen_q] <= sto1;
        if (bucket_on) fb_q[fb_idx] <= fb1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      out_if.point_starts <= sc1;
      out_if.point_ends <= ec1;
      out_if.point_total_us <= it1;
      out_if.point_max_us <= 48'(im1);
      out_if.point_load_total <= lo1;
      out_if.request_latency_us <= (cmd_q == CMD_FINISH) ? 48'(lat) : '0;
      out_if.request_timed_out <= fin && tmo_hit;
      out_if.fault_bucket <= (fin && bucket_on) ? (hi ? 2'd2 : 2'd1) : 2'd0;
      out_if.bucket_count <= (fin && bucket_on) ? fb1 : '0;
      out_if.scenario_total_us <= fin ? stot1 : '0;
      out_if.scenario_max_us <= fin ? 48'(smax1) : '0;
      out_if.scenario_timeouts <= fin ? sto1 : '0;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/latency_profile_table_top.sv
`default_nettype none
// Latency profile table: one command per transfer on the input channel, one
// result per valid command on the output channel (unknown commands and
// out-of-range checkpoints give none). Each command is first captured, then
// applied by a single read-modify-write of the addressed checkpoint row and, on
// finish, the scenario statistics; the result register then waits for its
// transfer, and the next command is captured in the cycle that the result
// transfers. Begin clears the whole table as part of its update. Timeout limits
// are written through the config channel only while the block is idle, a rule for the
// user that the block itself does not enforce; they reset to 2 s, 100 ms, 500 ms and 2 s.
module latency_profile_table_top #(
  parameter int NumScenarios = lpt_pkg::NumScenariosDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  lpt_in_if.sink    in_if,
  lpt_cfg_if.sink   cfg_if,
  lpt_out_if.source out_if
);
  import lpt_pkg::*;
  ctl_t ctl;
  logic drop;

  // Sequence capture, update and result hand-off.
  lpt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_drop_i(drop), .out_ready_i(out_if.ready),
    .in_ready_o(in_if.ready), .out_valid_o(out_if.valid), .ctl_o(ctl)
  );

  lpt_datapath #(.NumScenarios(NumScenarios))
  u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .drop_o(drop),
    .in_if(in_if), .cfg_if(cfg_if), .out_if(out_if)
  );
endmodule
`default_nettype wire

FILE: dv/tb_profile_board.sv
`timescale 1ns / 1ps
// Predicts the profile table and holds expected result items in order.
package tb_profile_pkg;
  import lpt_pkg::*;

  typedef struct packed {
    logic [31:0] starts;
    logic [31:0] ends;
    logic [63:0] total_us;
    logic [47:0] max_us;
    logic [63:0] load_total;
    logic [47:0] latency_us;
    logic        timed_out;
    logic [1:0]  bucket;
    logic [63:0] scen_total_us;
    logic [47:0] scen_max_us;
    logic [31:0] scen_timeouts;
    logic [31:0] bucket_count;
  } profile_res_t;

  class profile_board;
    logic [31:0] starts_q[15];
    logic [31:0] ends_q[15];
    logic [47:0] first_t[15];
    logic [47:0] last_t[15];
    logic [63:0] totals[15];
    logic [47:0] maxima[15];
    logic [63:0] last_ld[15];
    logic [63:0] ld_totals[15];
    logic [1:0]  scen;
    logic [63:0] scen_tot[4];
    logic [47:0] scen_max[4];
    logic [31:0] scen_to[4];
    logic [31:0] fbuckets[4];
    logic [23:0] limits[4];
    profile_res_t pending[$];
    int errors;

    function new();
      clear_rows();
      scen = 0;
      for (int i = 0; i < 4; i++) begin
        scen_tot[i] = 0; scen_max[i] = 0; scen_to[i] = 0; fbuckets[i] = 0;
      end
      limits[REG_RECLAIM] = TimeoutReclaimRst;
      limits[REG_FAULT] = TimeoutFaultRst;
      limits[REG_BATCH] = TimeoutBatchRst;
      limits[REG_PREFETCH] = TimeoutPrefetchRst;
      errors = 0;
    endfunction

    function void clear_rows();
      for (int i = 0; i < 15; i++) begin
        starts_q[i] = 0; ends_q[i] = 0; first_t[i] = 0; last_t[i] = 0;
        totals[i] = 0; maxima[i] = 0; last_ld[i] = 0; ld_totals[i] = 0;
      end
    endfunction

    function void enter(int p, logic [47:0] t, logic [63:0] ld);
      if (starts_q[p] == 0) first_t[p] = t;
      starts_q[p]++;
      last_t[p] = t;
      last_ld[p] = ld;
    endfunction

    function void leave(int p, logic [47:0] t, logic [63:0] ld);
      logic [47:0] d;
      d = t - last_t[p];
      totals[p] += 64'(d);
      if (d > maxima[p]) maxima[p] = d;
      ld_totals[p] += ld - last_ld[p];
      ends_q[p]++;
      last_t[p] = t;
      last_ld[p] = ld;
    endfunction

    function void write_limit(logic [1:0] idx, logic [23:0] v);
      limits[idx] = v;
    endfunction

    // Note one accepted command; queue its expected result if it makes one.
    function void note_command(cmd_e c, logic [3:0] p, logic [1:0] sc, logic [47:0] t,
                               logic [47:0] ts, logic [63:0] rn, logic [63:0] rs,
                               logic fg);
      profile_res_t r;
      int row;
      logic [47:0] lat;
      int idx;
      if (c > CMD_FINISH) return;
      if (c != CMD_BEGIN && c != CMD_FINISH && p >= 15) return;
      r = '0;
      row = p;
      case (c)
        CMD_BEGIN: begin
          clear_rows();
          scen = sc;
          row = 0;
          enter(0, ts, rs);
          ends_q[0]++;
        end
        CMD_START: enter(row, t, rn);
        CMD_END: leave(row, t, rn);
        CMD_MARK: begin
          enter(row, t, rn);
          ends_q[row]++;
        end
        CMD_ASYNC: begin
          enter(row, ts, rs);
          leave(row, t, (p == AsyncLoadA || p == AsyncLoadB) ? rn : 64'd0);
        end
        default: begin
          row = 14;
          enter(14, t, rn);
          ends_q[14]++;
          lat = first_t[14] - first_t[0];
          r.latency_us = lat;
          scen_tot[scen] += 64'(lat);
          if (lat > scen_max[scen]) scen_max[scen] = lat;
          if (lat > 48'(limits[scen])) begin
            scen_to[scen]++;
            r.timed_out = 1;
            if (scen == FaultScen) begin
              if (lat > BucketHiUs) begin
                idx = fg * 2 + 1; fbuckets[idx]++;
                r.bucket = 2; r.bucket_count = fbuckets[idx];
              end else if (lat > BucketLoUs) begin
                idx = fg * 2; fbuckets[idx]++;
                r.bucket = 1; r.bucket_count = fbuckets[idx];
              end
            end
          end
          r.scen_total_us = scen_tot[scen];
          r.scen_max_us = scen_max[scen];
          r.scen_timeouts = scen_to[scen];
        end
      endcase
      r.starts = starts_q[row];
      r.ends = ends_q[row];
      r.total_us = totals[row];
      r.max_us = maxima[row];
      r.load_total = ld_totals[row];
      pending.push_back(r);
    endfunction

    function void check_result(profile_res_t a);
      profile_res_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a === e) return;
      errors++;
      if (a.starts !== e.starts) $error("point_starts exp %0d got %0d", e.starts, a.starts);
      if (a.ends !== e.ends) $error("point_ends exp %0d got %0d", e.ends, a.ends);
      if (a.total_us !== e.total_us)
        $error("point_total_us exp %0d got %0d", e.total_us, a.total_us);
      if (a.max_us !== e.max_us) $error("point_max_us exp %0d got %0d", e.max_us, a.max_us);
      if (a.load_total !== e.load_total)
        $error("point_load_total exp %0d got %0d", e.load_total, a.load_total);
      if (a.latency_us !== e.latency_us)
        $error("request_latency_us exp %0d got %0d", e.latency_us, a.latency_us);
      if (a.timed_out !== e.timed_out)
        $error("request_timed_out exp %0d got %0d", e.timed_out, a.timed_out);
      if (a.bucket !== e.bucket) $error("fault_bucket exp %0d got %0d", e.bucket, a.bucket);
      if (a.scen_total_us !== e.scen_total_us)
        $error("scenario_total_us exp %0d got %0d", e.scen_total_us, a.scen_total_us);
      if (a.scen_max_us !== e.scen_max_us)
        $error("scenario_max_us exp %0d got %0d", e.scen_max_us, a.scen_max_us);
      if (a.scen_timeouts !== e.scen_timeouts)
        $error("scenario_timeouts exp %0d got %0d", e.scen_timeouts, a.scen_timeouts);
      if (a.bucket_count !== e.bucket_count)
        $error("bucket_count exp %0d got %0d", e.bucket_count, a.bucket_count);
    endfunction
  endclass
endpackage

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import lpt_pkg::*;
  import tb_profile_pkg::*;

  logic clk_i;
  logic rst_ni;

  lpt_in_if  in_if();
  lpt_out_if out_if();
  lpt_cfg_if cfg_if();

  latency_profile_table_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .cfg_if(cfg_if.sink),
    .out_if(out_if.source)
  );

  profile_board board;
  bit stim_done;
  // Running clock of the request under test; commands mostly move it forward.
  logic [47:0] now_us;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one, sometimes none at all.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  // Present one command and hold it until its transfer; keep valid high when
  // the next command follows with no gap.
  task automatic send_command(cmd_e c, logic [3:0] p, logic [1:0] sc, logic [47:0] t,
                              logic [47:0] ts, logic [63:0] rn, logic [63:0] rs,
                              logic fg);
    int g;
    in_if.valid <= 1;
    in_if.cmd <= c;
    in_if.point <= p;
    in_if.scenario <= sc;
    in_if.time_us <= t;
    in_if.start_time_us <= ts;
    in_if.ravg_now <= rn;
    in_if.ravg_start <= rs;
    in_if.foreground <= fg;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_command(c, p, sc, t, ts, rn, rs, fg);
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 0;
      idle_cycles(g);
    end
  endtask

  task automatic write_limit(reg_e idx, logic [23:0] v);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.data <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 0;
    board.write_limit(idx, v);
    @(posedge clk_i);
  endtask

  // Drain: drop valid, wait for every expected result, then let ignored
  // commands settle.
  task automatic drain();
    in_if.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    idle_cycles(8);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom()), $urandom()};
  endfunction

  // Advance the request clock by a small step, or rarely by a wild jump.
  function automatic logic [47:0] step_time();
    if ($urandom_range(0, 19) == 0) now_us = rand48();
    else now_us = now_us + 48'($urandom_range(0, 300000));
    return now_us;
  endfunction

  // One random command with random content; mostly valid, some noise.
  task automatic random_command();
    int r;
    cmd_e c;
    logic [3:0] p;
    logic [47:0] t;
    logic [47:0] ts;
    r = $urandom_range(0, 99);
    if (r < 5) c = CMD_BEGIN;
    else if (r < 30) c = CMD_START;
    else if (r < 55) c = CMD_END;
    else if (r < 67) c = CMD_MARK;
    else if (r < 80) c = CMD_ASYNC;
    else if (r < 94) c = CMD_FINISH;
    else c = cmd_e'($urandom_range(6, 7));
    p = ($urandom_range(0, 19) == 0) ? 4'd15 : 4'($urandom_range(0, 14));
    ts = now_us;
    t = step_time();
    send_command(c, p, 2'($urandom()), t, ts, rand64(), rand64(), 1'($urandom()));
  endtask

  // Well-formed request: begin, checkpoint pairs or async checkpoints, then finish.
  task automatic random_request();
    logic [1:0] sc;
    logic [47:0] t0;
    int n;
    logic [3:0] p;
    logic [47:0] ts;
    sc = 2'($urandom());
    t0 = ($urandom_range(0, 3) == 0) ? rand48() : 48'($urandom_range(0, 1000000));
    now_us = t0;
    send_command(CMD_BEGIN, 4'($urandom()), sc, rand48(), t0, rand64(), rand64(),
                 1'($urandom()));
    n = $urandom_range(1, 6);
    repeat (n) begin
      p = 4'($urandom_range(1, 13));
      if ($urandom_range(0, 3) == 0) begin
        ts = now_us;
        send_command(CMD_ASYNC, p, 2'($urandom()), step_time(), ts, rand64(), rand64(),
                     1'($urandom()));
      end else begin
        send_command(CMD_START, p, 2'($urandom()), step_time(), rand48(), rand64(),
                     rand64(), 1'($urandom()));
        if ($urandom_range(0, 4) == 0)
          send_command(CMD_MARK, 4'($urandom_range(0, 14)), 2'($urandom()), step_time(),
                       rand48(), rand64(), rand64(), 1'($urandom()));
        send_command(CMD_END, p, 2'($urandom()), step_time(), rand48(), rand64(),
                     rand64(), 1'($urandom()));
      end
    end
    send_command(CMD_FINISH, 4'($urandom()), 2'($urandom()), step_time(), rand48(),
                 rand64(), rand64(), 1'($urandom()));
  endtask

  task automatic fault_request(logic [47:0] lat, logic fg);
    send_command(CMD_BEGIN, 0, FaultScen, 0, 48'd1000, 0, 0, 0);
    send_command(CMD_FINISH, 0, 0, 48'd1000 + lat, 0, 0, 0, fg);
  endtask

  // Receiver: random stalls; check each result transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 0;
    end else begin
      if (out_if.valid && out_if.ready)
        board.check_result({out_if.point_starts, out_if.point_ends, out_if.point_total_us,
                            out_if.point_max_us, out_if.point_load_total,
                            out_if.request_latency_us, out_if.request_timed_out,
                            out_if.fault_bucket, out_if.scenario_total_us,
                            out_if.scenario_max_us, out_if.scenario_timeouts,
                            out_if.bucket_count});
      out_if.ready <= ($urandom_range(0, 99) < 70) ||
                      ($urandom_range(0, 99) < 15 && !stim_done ? 1'b0 : 1'b1) &&
                      $urandom_range(0, 1);
    end
  end

  initial begin
    board = new();
    stim_done = 0;
    now_us = 0;
    rst_ni = 0;
    in_if.valid = 0;
    in_if.cmd = CMD_BEGIN;
    in_if.point = 0;
    in_if.scenario = 0;
    in_if.time_us = 0;
    in_if.start_time_us = 0;
    in_if.ravg_now = 0;
    in_if.ravg_start = 0;
    in_if.foreground = 0;
    cfg_if.valid = 0;
    cfg_if.index = REG_RECLAIM;
    cfg_if.data = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Finish without begin, on the cleared table.
    send_command(CMD_FINISH, 0, 0, 48'hFFFF_FFFF_FFFF, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1);
    // Extremes, wrapping intervals and all-ones loads.
    send_command(CMD_BEGIN, 4'hF, 2'd3, 0, 48'hFFFF_FFFF_FFFF, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_command(CMD_START, 0, 0, 48'hFFFF_FFFF_FFF0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    send_command(CMD_END, 0, 0, 48'd5, 0, 0, 0, 0);
    send_command(CMD_MARK, 4'd14, 0, 48'd7, 0, 64'd3, 0, 0);
    send_command(CMD_ASYNC, 4'd10, 0, 48'd100, 48'd50, 64'd90, 64'd40, 0);
    send_command(CMD_ASYNC, 4'd11, 0, 48'd0, 48'hFFFF_FFFF_FFFF, 64'd1, 64'd2, 0);
    send_command(CMD_ASYNC, 4'd12, 0, 48'd100, 48'd50, 64'd90, 64'd40, 0);
    // Out-of-range checkpoints and unknown commands: no result.
    send_command(CMD_START, 4'd15, 0, 0, 0, 0, 0, 0);
    send_command(CMD_ASYNC, 4'd15, 0, 0, 0, 0, 0, 0);
    send_command(cmd_e'(3'd6), 0, 0, 0, 0, 0, 0, 0);
    send_command(cmd_e'(3'd7), 4'd15, 2'd3, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1);
    send_command(CMD_FINISH, 0, 0, 48'd3000000, 0, 0, 0, 0);
    // Fault buckets at the reset limit, around both thresholds, both task kinds.
    fault_request(48'd100000, 0);
    fault_request(48'd100001, 0);
    fault_request(48'd500000, 1);
    fault_request(48'd500001, 1);
    fault_request(48'd600000, 0);
    drain();

    // Fault limit below 100 ms: a latency above it times out but takes no bucket; other limits at extremes.
    write_limit(REG_RECLAIM, 24'd0);
    write_limit(REG_FAULT, 24'd10);
    write_limit(REG_BATCH, 24'hFF_FFFF);
    write_limit(REG_PREFETCH, 24'd1);
    fault_request(48'd50, 1);
    fault_request(48'd10, 0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_limit(REG_RECLAIM, phase == 3 ? 24'hFF_FFFF : 24'($urandom_range(0, 3000000)));
      write_limit(REG_FAULT, phase == 0 ? 24'd0 : 24'($urandom_range(0, 700000)));
      write_limit(REG_BATCH, 24'($urandom()));
      write_limit(REG_PREFETCH, phase == 1 ? 24'd0 : 24'($urandom_range(0, 3000000)));
      repeat (45) begin
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) random_command();
        else random_request();
      end
      drain();
    end
    stim_done = 1;
    drain();
    idle_cycles(20);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/lpt_pkg.sv
hdl/lpt_if.sv
hdl/lpt_ctrl.sv
hdl/lpt_datapath.sv
hdl/latency_profile_table_top.sv
dv/tb_profile_board.sv
dv/tb.sv
